### rtl/cawp_pkg.sv
// ----------------------------------------------------------------------------
// cawp_pkg: shared types and constants for the cave automaton window pass
// Tile codes, register indexes, reset values and the window column type.
// ----------------------------------------------------------------------------
package cawp_pkg;

  // Tile codes
  typedef logic [1:0] tile_t;
  localparam tile_t TILE_FLOOR    = 2'd0;
  localparam tile_t TILE_WALL     = 2'd1;
  localparam tile_t TILE_OTHER    = 2'd2;
  localparam tile_t TILE_RESERVED = 2'd3;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_MAP_WIDTH        = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAP_HEIGHT       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FLOOR_NEAR_LIMIT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FLOOR_RING_LIMIT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_GENERATION_COUNT = 3'd4;

  // Register reset values
  localparam logic [7:0] RST_MAP_WIDTH        = 8'd80;
  localparam logic [6:0] RST_MAP_HEIGHT       = 7'd24;
  localparam logic [3:0] RST_FLOOR_NEAR_LIMIT = 4'd5;
  localparam logic [5:0] RST_FLOOR_RING_LIMIT = 6'd2;
  localparam logic [3:0] RST_GENERATION_COUNT = 4'd4;

  // Geometry defaults
  localparam int DEFAULT_MAX_WIDTH  = 128;
  localparam int DEFAULT_MAX_HEIGHT = 64;

  // Window and rule constants
  localparam int WIN       = 5;   // window edge, in tiles
  localparam int STACK     = 4;   // earlier rows held per column
  localparam int WALL_KEEP = 5;   // 3x3 count that keeps a wall
  localparam int OUT_DEPTH = 4;   // result queue entries

  // One window column: non-floor bit per row (bit j = j rows back),
  // plus the full tile of the middle row
  typedef struct packed {
    logic [WIN-1:0] nf;
    tile_t          mid;
  } col_t;

  // Earlier rows of one map column, entry k = k+1 rows back
  typedef logic [STACK-1:0][1:0] stack_t;

  // Unused tile code folds into "other"
  function automatic tile_t tile_clean(input tile_t t);
    tile_clean = (t == TILE_RESERVED) ? TILE_OTHER : t;
  endfunction

endpackage

### rtl/cawp_cell.sv
// ----------------------------------------------------------------------------
// cawp_cell: one column cell of the 5x5 window chain
// Holds one window column, passes it on to the next cell on every shift,
// and reports the non-floor counts of its inner rows and of the whole column.
// ----------------------------------------------------------------------------
module cawp_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           shift,
  input  cawp_pkg::col_t col_in,
  output cawp_pkg::col_t col_out,
  output logic [1:0]     inner_cnt,
  output logic [2:0]     all_cnt
);
  import cawp_pkg::*;

  // Column register; reset fills with non-floor
  always_ff @(posedge clk) begin
    if (rst) begin
      col_out.nf  <= '1;
      col_out.mid <= TILE_WALL;
    end else if (shift) begin
      col_out <= col_in;
    end
  end

  // Per-column counts: rows 1..3 form the 3x3 part
  always_comb begin
    inner_cnt = 2'(col_out.nf[1]) + 2'(col_out.nf[2]) + 2'(col_out.nf[3]);
    all_cnt   = 3'(inner_cnt) + 3'(col_out.nf[0]) + 3'(col_out.nf[4]);
  end

endmodule

### rtl/cawp_line_buffer.sv
// ----------------------------------------------------------------------------
// cawp_line_buffer: column-stacked row memory
// One word per map column holds the four previous rows of that column.
// Registered read, single write port.
// ----------------------------------------------------------------------------
module cawp_line_buffer #(
  parameter int DEPTH = cawp_pkg::DEFAULT_MAX_WIDTH,
  parameter int AW    = $clog2(cawp_pkg::DEFAULT_MAX_WIDTH)
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output cawp_pkg::stack_t rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  cawp_pkg::stack_t wr_data
);
  import cawp_pkg::*;

  stack_t mem [DEPTH];

  // Read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

### rtl/cave_automaton_window_pass.sv
// ----------------------------------------------------------------------------
// cave_automaton_window_pass: one cave-smoothing generation per frame pass
// Streams a tile map in raster order through a 5x5 window built from a
// column-stacked line buffer and a chain of five column cells.
//
//  Channel  Handshake                    Payload
//  -------  ---------------------------  -------------------------------------
//  config   cfg_valid / cfg_ready        cfg_index, cfg_data
//  tiles    tile_valid / tile_ready      tile_in
//  results  result_valid / result_ready  tile_out, last_of_frame, final_pass
//
// One tile per cycle while the result queue has room; each result passes
// through the line buffer read, the window shift and the rule evaluation.
// cfg_ready is always high. No clearing pass after reset: buffer words for rows
// not yet written in the current frame are read but masked as non-floor.
// A four-entry result queue absorbs output stalls; tile_ready drops only
// when the queue plus the two stages in flight would fill it.
// ----------------------------------------------------------------------------
module cave_automaton_window_pass #(
  parameter int MAX_WIDTH  = cawp_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = cawp_pkg::DEFAULT_MAX_HEIGHT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cawp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cawp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             tile_valid,
  output logic                             tile_ready,
  input  cawp_pkg::tile_t                  tile_in,
  output logic                             result_valid,
  input  logic                             result_ready,
  output cawp_pkg::tile_t                  tile_out,
  output logic                             last_of_frame,
  output logic                             final_pass
);
  import cawp_pkg::*;

  localparam int WEFF = (MAX_WIDTH < 255) ? MAX_WIDTH : 255;
  localparam int HEFF = (MAX_HEIGHT < 127) ? MAX_HEIGHT : 127;
  localparam int CW   = $clog2(WEFF + 2);
  localparam int RW   = $clog2(HEFF + 2);
  localparam int AW   = $clog2(WEFF);
  localparam int PW   = $clog2(OUT_DEPTH);

  typedef struct packed {
    logic emit;
    logic interior;
    logic last;
    logic fin;
  } item_flags_t;

  typedef struct packed {
    tile_t tile;
    logic  last;
    logic  fin;
  } result_t;

  // Configuration registers
  logic [7:0] map_width;
  logic [6:0] map_height;
  logic [3:0] floor_near_limit;
  logic [5:0] floor_ring_limit;
  logic [3:0] generation_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width        <= RST_MAP_WIDTH;
      map_height       <= RST_MAP_HEIGHT;
      floor_near_limit <= RST_FLOOR_NEAR_LIMIT;
      floor_ring_limit <= RST_FLOOR_RING_LIMIT;
      generation_count <= RST_GENERATION_COUNT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAP_WIDTH:        map_width        <= cfg_data[7:0];
        REG_MAP_HEIGHT:       map_height       <= cfg_data[6:0];
        REG_FLOOR_NEAR_LIMIT: floor_near_limit <= cfg_data[3:0];
        REG_FLOOR_RING_LIMIT: floor_ring_limit <= cfg_data[5:0];
        REG_GENERATION_COUNT: generation_count <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Effective geometry and generation count
  logic [CW-1:0] eff_w;
  logic [RW-1:0] eff_h;
  logic [3:0]    gens;

  assign eff_w = (map_width > 8'(WEFF)) ? CW'(WEFF) : CW'(map_width);
  assign eff_h = (map_height > 7'(HEFF)) ? RW'(HEFF) : RW'(map_height);
  assign gens  = (generation_count == 4'd0) ? 4'd1 : generation_count;

  // Stream position and pass counter
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [3:0]    pass;
  logic [CW:0]   colx, wx;
  logic [RW:0]   rowx, hx;
  logic          col_wrap, row_wrap, pass_last, accept;

  assign accept    = tile_valid && tile_ready;
  assign colx      = {1'b0, col};
  assign wx        = {1'b0, eff_w};
  assign rowx      = {1'b0, row};
  assign hx        = {1'b0, eff_h};
  assign col_wrap  = colx >= wx + (CW+1)'(1);
  assign row_wrap  = rowx >= hx + (RW+1)'(1);
  assign pass_last = ({1'b0, pass} + 5'd1) >= {1'b0, gens};

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      pass <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        col <= '0;
        if (row_wrap) begin
          row  <= '0;
          pass <= pass_last ? 4'd0 : pass + 4'd1;
        end else begin
          row <= row + RW'(1);
        end
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  // Item classification at transfer time
  item_flags_t    flags0;
  logic           col_ok0;
  logic [WIN-1:0] row_ok0;

  always_comb begin
    flags0.emit     = (rowx >= (RW+1)'(2)) && (colx >= (CW+1)'(2)) &&
                      (rowx <= hx + (RW+1)'(1)) && (colx <= wx + (CW+1)'(1));
    flags0.interior = (rowx >= (RW+1)'(3)) && (colx >= (CW+1)'(3)) &&
                      (rowx <= hx) && (colx <= wx);
    flags0.last     = (rowx == hx + (RW+1)'(1)) && (colx == wx + (CW+1)'(1));
    flags0.fin      = pass_last;
    col_ok0         = colx < wx;
    // row j back is on the map when 0 <= row-j < h
    for (int j = 0; j < WIN; j++) begin
      row_ok0[j] = (rowx >= (RW+1)'(j)) && (rowx < hx + (RW+1)'(j));
    end
  end

  // Stage 1 registers: tile and masks, buffer read in flight
  logic           s1_valid;
  item_flags_t    s1_flags;
  tile_t          s1_tile;
  logic           s1_col_ok;
  logic [WIN-1:0] s1_row_ok;
  logic [AW-1:0]  s1_addr;
  stack_t         rd_data, wr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_flags  <= flags0;
      s1_tile   <= tile_clean(tile_in);
      s1_col_ok <= col_ok0;
      s1_row_ok <= row_ok0;
      s1_addr   <= col[AW-1:0];
    end
  end

  cawp_line_buffer #(
    .DEPTH (WEFF),
    .AW    (AW)
  ) u_line_buffer (
    .clk     (clk),
    .rd_en   (accept && col_ok0),
    .rd_addr (col[AW-1:0]),
    .rd_data (rd_data),
    .wr_en   (s1_valid && s1_col_ok),
    .wr_addr (s1_addr),
    .wr_data (wr_data)
  );

  // Assemble the new window column; off-map reads count as non-floor
  tile_t col_tiles [WIN];
  col_t  new_col;

  always_comb begin
    col_tiles[0] = s1_tile;
    for (int k = 0; k < STACK; k++) begin
      col_tiles[k+1] = rd_data[k];
      wr_data[k]     = col_tiles[k];
    end
    for (int j = 0; j < WIN; j++) begin
      new_col.nf[j] = !(s1_row_ok[j] && s1_col_ok) || (col_tiles[j] != TILE_FLOOR);
    end
    new_col.mid = col_tiles[2];
  end

  // Window chain: cell 0 holds the newest column
  col_t       chain_in  [WIN];
  col_t       cell_col  [WIN];
  logic [1:0] inner_cnt [WIN];
  logic [2:0] all_cnt   [WIN];

  genvar gi;
  generate
    for (gi = 0; gi < WIN; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        assign chain_in[gi] = new_col;
      end else begin : g_link
        assign chain_in[gi] = cell_col[gi-1];
      end
      cawp_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .shift     (s1_valid),
        .col_in    (chain_in[gi]),
        .col_out   (cell_col[gi]),
        .inner_cnt (inner_cnt[gi]),
        .all_cnt   (all_cnt[gi])
      );
    end
  endgenerate

  // Stage 2: rule evaluation on the settled window
  logic        s2_valid;
  item_flags_t s2_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_flags <= s1_flags;
    end
  end

  logic [3:0]        near;
  logic [4:0]        total, ring;
  logic signed [6:0] ring_s, lim_s;
  tile_t             centre, next_tile;

  always_comb begin
    near  = '0;
    total = '0;
    for (int i = 0; i < WIN; i++) begin
      total = total + 5'(all_cnt[i]);
      if (i >= 1 && i <= 3) begin
        near = near + 4'(inner_cnt[i]);
      end
    end
    ring   = total - 5'(near);
    ring_s = $signed({2'b00, ring});
    lim_s  = $signed({floor_ring_limit[5], floor_ring_limit});
    centre = cell_col[2].mid;
    next_tile = centre;
    if (s2_flags.interior) begin
      case (centre)
        TILE_WALL:  next_tile = (near >= 4'(WALL_KEEP)) ? TILE_WALL : TILE_FLOOR;
        TILE_FLOOR: next_tile = ((near >= floor_near_limit) || (ring_s <= lim_s)) ?
                                TILE_WALL : TILE_FLOOR;
        default:    next_tile = centre;
      endcase
    end
  end

  // Result queue
  result_t      queue [OUT_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count, claimed;
  logic          push, pop;

  assign push         = s2_valid && s2_flags.emit;
  assign pop          = result_valid && result_ready;
  assign result_valid = count != '0;
  assign claimed      = count + (PW+1)'(s1_valid) + (PW+1)'(s2_valid);
  assign tile_ready   = claimed < (PW+1)'(OUT_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= '{tile: next_tile, last: s2_flags.last, fin: s2_flags.fin};
    end
  end

  assign tile_out      = queue[rd_ptr].tile;
  assign last_of_frame = queue[rd_ptr].last;
  assign final_pass    = queue[rd_ptr].fin;

  // Checks
  a_claim_bound: assert property (@(posedge clk) disable iff (rst)
    claimed <= (PW+1)'(OUT_DEPTH))
    else $error("items in flight exceed result queue depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |-> (count < (PW+1)'(OUT_DEPTH)))
    else $error("result queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("result queue underflow");

  a_stage_flow: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid ##1 s2_valid)
    else $error("transfer lost between pipeline stages");

  a_last_emits: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s2_flags.last) |-> s2_flags.emit)
    else $error("frame end flagged on an item with no result");

  a_code_legal: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (tile_out != TILE_RESERVED))
    else $error("unused tile code on result");

endmodule

### verif/cawp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cawp_checker: result predictor and scoreboard for the cave automaton pass
// Watches the config, tile and result channels. Keeps its own copy of the
// registers, the last five map rows and the stream position, works out the
// next-generation tile for each map cell as its window fills, and compares each result
// transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module cawp_checker #(
  parameter int MAX_WIDTH  = cawp_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = cawp_pkg::DEFAULT_MAX_HEIGHT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [cawp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cawp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             tile_valid,
  input  logic                             tile_ready,
  input  cawp_pkg::tile_t                  tile_in,
  input  logic                             result_valid,
  input  logic                             result_ready,
  input  cawp_pkg::tile_t                  tile_out,
  input  logic                             last_of_frame,
  input  logic                             final_pass,
  output int                               fail_count,
  output int                               pending
);
  import cawp_pkg::*;

  localparam int LINE_ROWS = 5;   // map rows the window can reach

  typedef struct packed {
    tile_t tile;
    logic  last;
    logic  fin;
  } cell_result_t;

  cell_result_t expected_cells[$];

  // Register copies
  logic [7:0]        map_w_reg;
  logic [6:0]        map_h_reg;
  logic [3:0]        near_lim_reg;
  logic signed [5:0] ring_lim_reg;
  logic [3:0]        gen_reg;

  // Line store and stream position
  tile_t line_rows [LINE_ROWS][MAX_WIDTH];
  int    col_pos;
  int    row_pos;
  int    pass_idx;

  int fails   = 0;
  int waiting = 0;

  assign fail_count = fails;
  assign pending    = waiting;

  // Off-map reads count as wall
  function automatic tile_t map_cell(int y, int x, int w, int h);
    if (y < 0 || x < 0 || y >= h || x >= w) return TILE_WALL;
    return line_rows[y % LINE_ROWS][x];
  endfunction

  task automatic reset_model();
    map_w_reg    = RST_MAP_WIDTH;
    map_h_reg    = RST_MAP_HEIGHT;
    near_lim_reg = RST_FLOOR_NEAR_LIMIT;
    ring_lim_reg = RST_FLOOR_RING_LIMIT;
    gen_reg      = RST_GENERATION_COUNT;
    col_pos      = 0;
    row_pos      = 0;
    pass_idx     = 0;
    expected_cells.delete();
  endtask

  task automatic apply_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] data);
    case (idx)
      REG_MAP_WIDTH:        map_w_reg    = data;
      REG_MAP_HEIGHT:       map_h_reg    = data[6:0];
      REG_FLOOR_NEAR_LIMIT: near_lim_reg = data[3:0];
      REG_FLOOR_RING_LIMIT: ring_lim_reg = data[5:0];
      REG_GENERATION_COUNT: gen_reg      = data[3:0];
      default: ;
    endcase
  endtask

  // Store the tile, emit the cell two rows and two columns back, advance
  task automatic predict_cell(input tile_t raw);
    int           w, h, gens, y, x, near, ring;
    tile_t        t, centre, nxt;
    cell_result_t item;
    w    = (map_w_reg > MAX_WIDTH) ? MAX_WIDTH : int'(map_w_reg);
    h    = (map_h_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(map_h_reg);
    gens = (gen_reg == 0) ? 1 : int'(gen_reg);
    t    = (raw == TILE_RESERVED) ? TILE_OTHER : raw;
    if (row_pos < h && col_pos < w) line_rows[row_pos % LINE_ROWS][col_pos] = t;

    if (row_pos >= 2 && col_pos >= 2 && row_pos <= h + 1 && col_pos <= w + 1) begin
      y      = row_pos - 2;
      x      = col_pos - 2;
      centre = map_cell(y, x, w, h);
      nxt    = centre;
      // Border cells and other tiles pass through
      if (y > 0 && x > 0 && y < h - 1 && x < w - 1) begin
        near = 0;
        ring = 0;
        for (int dy = -2; dy <= 2; dy++) begin
          for (int dx = -2; dx <= 2; dx++) begin
            if (map_cell(y + dy, x + dx, w, h) != TILE_FLOOR) begin
              if (dy == -2 || dy == 2 || dx == -2 || dx == 2) ring++;
              else near++;
            end
          end
        end
        if (centre == TILE_WALL) begin
          nxt = (near >= WALL_KEEP) ? TILE_WALL : TILE_FLOOR;
        end else if (centre == TILE_FLOOR) begin
          nxt = (near >= int'(near_lim_reg) || ring <= int'(ring_lim_reg)) ?
                TILE_WALL : TILE_FLOOR;
        end
      end
      item.tile = nxt;
      item.last = (row_pos == h + 1 && col_pos == w + 1);
      item.fin  = (pass_idx + 1 >= gens);
      expected_cells.insert(expected_cells.size(), item);
    end

    col_pos++;
    if (col_pos >= w + 2) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h + 2) begin
        row_pos  = 0;
        pass_idx = (pass_idx + 1 >= gens) ? 0 : pass_idx + 1;
      end
    end
  endtask

  task automatic check_result();
    cell_result_t want;
    if (expected_cells.size() == 0) begin
      fails++;
      $display("%0t: result with nothing expected: tile_out=%0d last_of_frame=%0b final_pass=%0b",
               $time, tile_out, last_of_frame, final_pass);
    end else begin
      want = expected_cells.pop_front();
      if (tile_out !== want.tile) begin
        fails++;
        $display("%0t: tile_out expected %0d actual %0d", $time, want.tile, tile_out);
      end
      if (last_of_frame !== want.last) begin
        fails++;
        $display("%0t: last_of_frame expected %0b actual %0b", $time, want.last,
                 last_of_frame);
      end
      if (final_pass !== want.fin) begin
        fails++;
        $display("%0t: final_pass expected %0b actual %0b", $time, want.fin, final_pass);
      end
    end
  endtask

  // Results always come after their tile, so check before predicting
  always @(posedge clk) begin
    if (rst) begin
      reset_model();
    end else begin
      if (cfg_valid && cfg_ready) apply_cfg(cfg_index, cfg_data);
      if (result_valid && result_ready) check_result();
      if (tile_valid && tile_ready) predict_cell(tile_in);
    end
    waiting = expected_cells.size();
  end

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the cave automaton window pass
// Streams whole frames (map plus flush items) under a series of register
// settings: two hand-built maps first, then random maps of mostly small size
// with a few extreme and oversized geometries. Sender and receiver idle at
// random in two of three phases. The checker beside the block does all comparing.
// ----------------------------------------------------------------------------
module tb_top;
  import cawp_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int ITEM_TARGET   = 1200;
  localparam int SETTLE_CYCLES = 8;     // pipeline depth plus margin
  localparam int MAP_MAX_W     = DEFAULT_MAX_WIDTH;
  localparam int MAP_MAX_H     = DEFAULT_MAX_HEIGHT;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

  // Hand-built maps, row major; the 3x3 frame uses the top-left corner
  localparam tile_t CAVE_A [25] = '{
    TILE_WALL,  TILE_WALL,  TILE_WALL,     TILE_WALL,  TILE_WALL,
    TILE_WALL,  TILE_FLOOR, TILE_FLOOR,    TILE_FLOOR, TILE_WALL,
    TILE_WALL,  TILE_FLOOR, TILE_RESERVED, TILE_FLOOR, TILE_OTHER,
    TILE_WALL,  TILE_WALL,  TILE_FLOOR,    TILE_FLOOR, TILE_WALL,
    TILE_OTHER, TILE_WALL,  TILE_WALL,     TILE_FLOOR, TILE_WALL
  };
  localparam tile_t CAVE_B [25] = '{
    TILE_WALL,  TILE_FLOOR, TILE_FLOOR, TILE_FLOOR, TILE_FLOOR,
    TILE_FLOOR, TILE_FLOOR, TILE_FLOOR, TILE_FLOOR, TILE_FLOOR,
    TILE_OTHER, TILE_FLOOR, TILE_FLOOR, TILE_FLOOR, TILE_FLOOR,
    TILE_FLOOR, TILE_FLOOR, TILE_FLOOR, TILE_FLOOR, TILE_FLOOR,
    TILE_FLOOR, TILE_FLOOR, TILE_FLOOR, TILE_FLOOR, TILE_FLOOR
  };

  logic                   clk;
  logic                   rst          = 1'b1;
  logic                   cfg_valid    = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [CFG_DATA_W-1:0]  cfg_data     = '0;
  logic                   tile_valid   = 1'b0;
  logic                   tile_ready;
  tile_t                  tile_in      = TILE_FLOOR;
  logic                   result_valid;
  logic                   result_ready = 1'b0;
  tile_t                  tile_out;
  logic                   last_of_frame;
  logic                   final_pass;

  int fail_count;
  int pending;

  int          send_idle    = 17;
  int          recv_idle    = 80;
  int          sent_items   = 0;
  int          wall_pct     = 50;
  int          cycles       = 0;
  logic [7:0]  cur_w        = RST_MAP_WIDTH;
  logic [6:0]  cur_h        = RST_MAP_HEIGHT;

  cave_automaton_window_pass #(
    .MAX_WIDTH (MAP_MAX_W),
    .MAX_HEIGHT(MAP_MAX_H)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .tile_valid   (tile_valid),
    .tile_ready   (tile_ready),
    .tile_in      (tile_in),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .tile_out     (tile_out),
    .last_of_frame(last_of_frame),
    .final_pass   (final_pass)
  );

  cawp_checker #(
    .MAX_WIDTH (MAP_MAX_W),
    .MAX_HEIGHT(MAP_MAX_H)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .tile_valid   (tile_valid),
    .tile_ready   (tile_ready),
    .tile_in      (tile_in),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .tile_out     (tile_out),
    .last_of_frame(last_of_frame),
    .final_pass   (final_pass),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    result_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // One tile transfer, with random gaps ahead of it
  task automatic send_tile(input tile_t t);
    while ($urandom_range(0, 99) < send_idle) begin
      tile_valid <= 1'b0;
      @(negedge clk);
    end
    tile_valid <= 1'b1;
    tile_in    <= t;
    @(posedge clk);
    while (!tile_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Map tile mix for the current frame
  function automatic tile_t random_tile();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return TILE_RESERVED;
    if (roll < 8) return TILE_OTHER;
    if (roll < 8 + wall_pct) return TILE_WALL;
    return TILE_FLOOR;
  endfunction

  // Leaves cfg_valid high; the caller drops it after the last write
  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop sending and let the block drain
  task automatic settle();
    tile_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write every register while idle; unused upper data bits carry junk
  task automatic program_map(input logic [7:0] w, input logic [6:0] h,
                             input logic [3:0] near_lim, input logic [5:0] ring_lim,
                             input logic [3:0] gens, input bit poke_unused);
    logic [7:0] junk;
    junk = 8'($urandom);
    settle();
    if (poke_unused) cfg_write(REG_UNUSED, junk);
    cfg_write(REG_MAP_WIDTH, w);
    cfg_write(REG_MAP_HEIGHT, {junk[7], h});
    cfg_write(REG_FLOOR_NEAR_LIMIT, {junk[7:4], near_lim});
    cfg_write(REG_FLOOR_RING_LIMIT, {junk[7:6], ring_lim});
    cfg_write(REG_GENERATION_COUNT, {junk[3:0], gens});
    cfg_valid <= 1'b0;
    cur_w = w;
    cur_h = h;
  endtask

  // One full pass: map rows plus two flush columns and rows
  task automatic stream_frame(input int pause_at, input bit use_map,
                              input tile_t cave [25]);
    int    w, h, n;
    tile_t t;
    w        = (cur_w > MAP_MAX_W) ? MAP_MAX_W : int'(cur_w);
    h        = (cur_h > MAP_MAX_H) ? MAP_MAX_H : int'(cur_h);
    wall_pct = $urandom_range(25, 75);
    n        = 0;
    for (int r = 0; r < h + 2; r++) begin
      for (int c = 0; c < w + 2; c++) begin
        // Hold off until every result so far has come out
        if (n == pause_at) begin
          tile_valid <= 1'b0;
          @(negedge clk);
          while (pending != 0) @(negedge clk);
        end
        if (r < h && c < w) t = use_map ? cave[r * 5 + c] : random_tile();
        else t = tile_t'($urandom_range(0, 3));
        sent_items++;
        send_idle = (sent_items < 400) ? 17 : (sent_items < 800) ? 80 : 0;
        recv_idle = (sent_items < 400) ? 80 : (sent_items < 800) ? 17 : 0;
        send_tile(t);
        n++;
      end
    end
  endtask

  // Stimulus and verdict
  initial begin
    int         frame_no;
    int         ext_idx;
    logic [7:0] w;
    logic [6:0] h;
    frame_no = 0;
    ext_idx  = 0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: 5x5 map, rules at their limits, ring rule off
    program_map(8'd5, 7'd5, 4'd10, 6'h3F, 4'd1, 1'b1);
    stream_frame(30, 1'b1, CAVE_A);
    // Directed: one interior cell, a floor that the near rule turns to wall
    program_map(8'd3, 7'd3, 4'd0, 6'h10, 4'd2, 1'b0);
    stream_frame(-1, 1'b1, CAVE_B);
    // Reset rule settings on a small map
    program_map(8'd12, 7'd8, RST_FLOOR_NEAR_LIMIT,
                RST_FLOOR_RING_LIMIT, RST_GENERATION_COUNT, 1'b0);
    stream_frame(-1, 1'b0, CAVE_A);

    // Random frames, with extreme geometries spread among them
    while (sent_items < ITEM_TARGET || ext_idx < 2) begin
      if (frame_no % 2 == 1 && ext_idx < 2) begin
        case (ext_idx)
          0:       begin w = 8'd255; h = 7'd3;   end
          default: begin w = 8'd3;   h = 7'd127; end
        endcase
        program_map(w, h, 4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)),
                    4'($urandom_range(0, 15)), 1'b0);
        stream_frame(-1, 1'b0, CAVE_A);
        ext_idx++;
      end else begin
        if (frame_no == 0 || $urandom_range(0, 2) != 0) begin
          w = ($urandom_range(0, 11) == 0) ? 8'($urandom_range(0, 4)) :
                                             8'($urandom_range(5, 14));
          h = ($urandom_range(0, 11) == 0) ? 7'($urandom_range(0, 4)) :
                                             7'($urandom_range(5, 9));
          program_map(w, h, 4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)),
                      4'($urandom_range(0, 15)), 1'b0);
        end
        stream_frame(-1, 1'b0, CAVE_A);
      end
      frame_no++;
    end

    // Drain and decide
    tile_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
